>>> rtl/ffha_pkg.sv
// ============================================================================
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ============================================================================
package ffha_pkg;

  // Region geometry
  localparam int HEAP_BYTES = 65536;
  localparam int WORD_COUNT = HEAP_BYTES / 2;
  localparam int ADDR_W     = $clog2(WORD_COUNT);
  localparam int END_WORD   = WORD_COUNT - 1;

  // Header of the single free block that spans the region after reset
  localparam logic [15:0] INIT_HDR = 16'((HEAP_BYTES - 2) & 16'hFFFE);

  // Reset value of the split threshold
  localparam logic [15:0] MIN_SPLIT_RESET = 16'd64;

  // Operation codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_NOT_USED = 2'd2;

  typedef logic [ADDR_W-1:0] widx_t;

  // Access request from the walker to the heap memory
  typedef struct packed {
    logic        re;
    widx_t       raddr;
    logic        we;
    widx_t       waddr;
    logic [15:0] wdata;
  } mem_req_t;

endpackage

>>> rtl/ffha_heap_mem.sv
// ============================================================================
// ffha_heap_mem
// Header word store: one write and one registered read port. Word 0 reads as
// the initial free-block header until it is first written.
// ============================================================================
module ffha_heap_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  ffha_pkg::mem_req_t req,
  output logic [15:0]       rdata
);

  logic [15:0]     mem [ffha_pkg::WORD_COUNT];
  logic [15:0]     rdata_r;
  ffha_pkg::widx_t raddr_r;
  logic            w0_written_r;

  // Memory array
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
      raddr_r <= req.raddr;
    end
  end

  // Tracks whether word 0 still holds its reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w0_written_r <= 1'b0;
    end else if (req.we && (req.waddr == '0)) begin
      w0_written_r <= 1'b1;
    end
  end

  assign rdata = ((raddr_r == '0) && !w0_written_r) ? ffha_pkg::INIT_HDR : rdata_r;

endmodule

>>> rtl/ffha_walker.sv
// ============================================================================
// ffha_walker
// Transaction sequencer: walks the header chain one header per memory read,
// merges free neighbours, takes the first fit and splits it; handles frees.
// ============================================================================
module ffha_walker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic [15:0]        in_size,
  input  logic [15:0]        in_addr,
  input  logic [15:0]        min_split,
  output ffha_pkg::mem_req_t mem_req,
  input  logic [15:0]        mem_rdata,
  output logic               out_valid,
  output logic [15:0]        out_result_addr,
  output logic [1:0]         out_status
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;
  localparam logic [1:0] S_SPLIT = 2'd3;

  localparam ffha_pkg::widx_t END_IDX = ffha_pkg::ADDR_W'(ffha_pkg::END_WORD);

  logic [1:0]      state_r, state_nxt;
  logic            op_r, op_nxt;
  logic [15:0]     need_r, need_nxt;
  ffha_pkg::widx_t p_r, p_nxt;
  ffha_pkg::widx_t prev_r, prev_nxt;
  logic            prev_free_r, prev_free_nxt;
  logic [15:0]     prev_bs_r, prev_bs_nxt;
  ffha_pkg::widx_t split_addr_r, split_addr_nxt;
  logic [15:0]     rem_r, rem_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [15:0]     out_addr_r, out_addr_nxt;
  logic [1:0]      out_status_r, out_status_nxt;

  logic [16:0]     need_full;
  logic [15:0]     free_off;
  logic [15:0]     bs;
  logic [16:0]     nxt_end;
  logic [15:0]     mbs;
  ffha_pkg::widx_t base;
  logic [15:0]     rem;
  logic            split;

  // Decode of the accepted item
  assign need_full = ({1'b0, in_size} + 17'd3) & 17'h1FFFE;
  assign free_off  = in_addr - 16'd2;

  // Header arithmetic on the word just read
  assign bs      = {mem_rdata[15:1], 1'b0};
  assign nxt_end = 17'(p_r) + 17'(bs[15:1]);
  assign mbs     = prev_free_r ? (bs + prev_bs_r) : bs;
  assign base    = prev_free_r ? prev_r : p_r;
  assign rem     = mbs - need_r;
  assign split   = (rem != 16'd0) && (rem >= min_split);

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    need_nxt       = need_r;
    p_nxt          = p_r;
    prev_nxt       = prev_r;
    prev_free_nxt  = prev_free_r;
    prev_bs_nxt    = prev_bs_r;
    split_addr_nxt = split_addr_r;
    rem_nxt        = rem_r;
    out_valid_nxt  = 1'b0;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    mem_req        = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt        = in_func;
          need_nxt      = need_full[15:0];
          prev_free_nxt = 1'b0;
          out_addr_nxt  = 16'd0;
          if (in_func == ffha_pkg::FUNC_FREE) begin
            if (free_off[15:1] >= 15'(ffha_pkg::END_WORD)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ffha_pkg::ST_NOT_USED;
            end else begin
              p_nxt     = ffha_pkg::ADDR_W'(free_off[15:1]);
              state_nxt = S_ISSUE;
            end
          end else if (need_full[16]) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ffha_pkg::ST_NO_FIT;
          end else begin
            p_nxt     = '0;
            state_nxt = S_ISSUE;
          end
        end
      end

      S_ISSUE: begin
        // End-of-list word always reads as zero: no access needed
        if (p_r == END_IDX) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ffha_pkg::ST_NO_FIT;
          state_nxt      = S_IDLE;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = p_r;
          state_nxt     = S_EVAL;
        end
      end

      S_EVAL: begin
        if (op_r == ffha_pkg::FUNC_FREE) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (mem_rdata[0]) begin
            mem_req.we     = 1'b1;
            mem_req.waddr  = p_r;
            mem_req.wdata  = bs;
            out_status_nxt = ffha_pkg::ST_OK;
          end else begin
            out_status_nxt = ffha_pkg::ST_NOT_USED;
          end
        end else if ((mem_rdata == 16'd0) || (bs == 16'd0) ||
                     (nxt_end > 17'(ffha_pkg::END_WORD))) begin
          // End of list or broken chain
          out_valid_nxt  = 1'b1;
          out_status_nxt = ffha_pkg::ST_NO_FIT;
          state_nxt      = S_IDLE;
        end else if (!mem_rdata[0]) begin
          if (mbs >= need_r) begin
            // First fit: mark used, split off the leftover if large enough
            mem_req.we    = 1'b1;
            mem_req.waddr = base;
            mem_req.wdata = (split ? need_r : mbs) | 16'd1;
            out_addr_nxt  = 16'({16'(base), 1'b0} + 17'd2);
            if (split) begin
              split_addr_nxt = ffha_pkg::ADDR_W'(17'(base) + 17'(need_r[15:1]));
              rem_nxt        = rem;
              state_nxt      = S_SPLIT;
            end else begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ffha_pkg::ST_OK;
              state_nxt      = S_IDLE;
            end
          end else begin
            // Too small: merge into a free predecessor, go on
            if (prev_free_r) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = base;
              mem_req.wdata = mbs;
            end
            prev_free_nxt = 1'b1;
            prev_nxt      = base;
            prev_bs_nxt   = mbs;
            p_nxt         = ffha_pkg::ADDR_W'(17'(base) + 17'(mbs[15:1]));
            state_nxt     = S_ISSUE;
          end
        end else begin
          // Block in use
          prev_free_nxt = 1'b0;
          p_nxt         = ffha_pkg::ADDR_W'(nxt_end);
          state_nxt     = S_ISSUE;
        end
      end

      S_SPLIT: begin
        mem_req.we     = 1'b1;
        mem_req.waddr  = split_addr_r;
        mem_req.wdata  = rem_r;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ffha_pkg::ST_OK;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    need_r       <= need_nxt;
    p_r          <= p_nxt;
    prev_r       <= prev_nxt;
    prev_free_r  <= prev_free_nxt;
    prev_bs_r    <= prev_bs_nxt;
    split_addr_r <= split_addr_nxt;
    rem_r        <= rem_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_result_addr = out_addr_r;
  assign out_status      = out_status_r;

endmodule

>>> rtl/first_fit_heap_allocator.sv
// ============================================================================
// first_fit_heap_allocator
// First-fit allocator over an implicit list of block headers in one memory.
// ============================================================================
// Sequence: an allocate alternates a header read and its evaluation for each
//   header, adds a write state when the chosen block is split and answers
//   without a read at the end-of-list word; a free reads and checks one header.
//   Overflowing sizes and out-of-region frees answer in the cycle after start.
// Throughput: one transaction at a time; busy is low in the result cycle.
// Reset: walker idle, threshold 64, word 0 reads as one free block; no clear.
module first_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [15:0] in_size,
  input  logic [15:0] in_addr,
  output logic        out_valid,
  output logic [15:0] out_result_addr,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0]        min_split_r;
  ffha_pkg::mem_req_t mem_req;
  logic [15:0]        mem_rdata;

  // Split threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_split_r <= ffha_pkg::MIN_SPLIT_RESET;
    end else if (cfg_we) begin
      min_split_r <= cfg_wdata;
    end
  end

  ffha_walker u_walker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_size         (in_size),
    .in_addr         (in_addr),
    .min_split       (min_split_r),
    .mem_req         (mem_req),
    .mem_rdata       (mem_rdata),
    .out_valid       (out_valid),
    .out_result_addr (out_result_addr),
    .out_status      (out_status)
  );

  ffha_heap_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule
